// ===== rtl/b64d_pkg.sv =====
// Package: shared types, constants and the character-to-sextet mapping of the base64 decoder.
`default_nettype none
package b64d_pkg;

  // Character and sextet constants.
  localparam logic [7:0] PadChar       = 8'h3D;
  localparam logic [7:0] PlusChar      = 8'h2B;
  localparam logic [7:0] SlashChar     = 8'h2F;
  localparam logic [6:0] UnknownSextet = 7'd64;
  localparam logic [6:0] PlusSextet    = 7'd62;
  localparam logic [6:0] SlashSextet   = 7'd63;
  localparam int unsigned AccumWidth   = 26;
  localparam int unsigned BytesPerGroup = 3;

  // Group position codes.
  localparam logic [1:0] PosFirst  = 2'd0;
  localparam logic [1:0] PosSecond = 2'd1;
  localparam logic [1:0] PosThird  = 2'd2;
  localparam logic [1:0] PosFourth = 2'd3;

  // Input item.
  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
    logic       length_error;
    logic       bad_char;
  } out_item_t;

  // One group's worth of results handed from the decoder to the emitter.
  typedef struct packed {
    logic [BytesPerGroup-1:0][7:0] bytes;
    logic [1:0]                    count;
    logic                          stream_end;
    logic                          length_error;
    logic                          bad_char;
  } group_res_t;

  // Map one raw character to its sextet; unknown characters give 64.
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [7:0] diff;
    logic [6:0] res;
    diff = 8'h00;
    res  = UnknownSextet;
    if (ch inside {[8'h41:8'h5A]}) begin
      diff = ch - 8'h41;
      res  = diff[6:0];
    end else if (ch inside {[8'h61:8'h7A]}) begin
      diff = ch - 8'h61 + 8'd26;
      res  = diff[6:0];
    end else if (ch inside {[8'h30:8'h39]}) begin
      diff = ch - 8'h30 + 8'd52;
      res  = diff[6:0];
    end else if (ch == PlusChar) begin
      res = PlusSextet;
    end else if (ch == SlashChar) begin
      res = SlashSextet;
    end else if (ch == PadChar) begin
      res = 7'd0;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/b64d_decode.sv =====
// Input register, sextet mapping and group accumulation of the base64 decoder.
`default_nettype none
module b64d_decode import b64d_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_item_t   in_item_i,
  input  wire logic       grp_ready_i,
  output logic            grp_valid_o,
  output group_res_t      grp_o
);

  logic                  in_valid_q;
  in_item_t              in_q;
  logic [AccumWidth-1:0] acc_q, acc_d;
  logic [1:0]            pos_q;
  logic                  third_pad_q;
  logic                  bad_q;

  logic [6:0]            sextet;
  logic [AccumWidth-1:0] term;
  logic                  is_pad;
  logic                  bad_now;
  logic                  needs_out;
  logic                  advance;
  logic [1:0]            drop;

  // Decode the registered character.
  always_comb begin
    sextet  = sextet_of(in_q.in_char);
    is_pad  = (in_q.in_char == PadChar);
    bad_now = bad_q | (sextet == UnknownSextet);
    case (pos_q)
      PosFirst:  term = {1'b0, sextet, 18'd0};
      PosSecond: term = {7'd0, sextet, 12'd0};
      PosThird:  term = {13'd0, sextet, 6'd0};
      PosFourth: term = {19'd0, sextet};
      default:   term = '0;
    endcase
    acc_d = acc_q + term;
  end

  // A result is due on the fourth character or on an early end.
  assign needs_out = in_q.in_last | (pos_q == PosFourth);
  assign advance   = in_valid_q & (~needs_out | grp_ready_i);
  assign in_stall_o = in_valid_q & ~advance;

  // Build the group result; padding only trims bytes in the final group.
  always_comb begin
    drop = {1'b0, in_q.in_last & is_pad} + {1'b0, in_q.in_last & third_pad_q};
    grp_o = '0;
    grp_o.bad_char = bad_now;
    if (pos_q == PosFourth) begin
      grp_o.bytes[0]   = acc_d[7:0];
      grp_o.bytes[1]   = acc_d[15:8];
      grp_o.bytes[2]   = acc_d[23:16];
      grp_o.count      = 2'd3 - drop;
      grp_o.stream_end = in_q.in_last;
    end else begin
      grp_o.count        = 2'd1;
      grp_o.stream_end   = 1'b1;
      grp_o.length_error = 1'b1;
    end
  end

  assign grp_valid_o = in_valid_q & needs_out;

  // Input register: takes a new transfer whenever it is empty or the held item moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || advance) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((!in_valid_q || advance) && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  // Group state: cleared after every emitting character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pos_q       <= PosFirst;
      third_pad_q <= 1'b0;
      bad_q       <= 1'b0;
    end else if (advance) begin
      if (needs_out) begin
        acc_q       <= '0;
        pos_q       <= PosFirst;
        third_pad_q <= 1'b0;
        bad_q       <= 1'b0;
      end else begin
        acc_q <= acc_d;
        pos_q <= pos_q + 2'd1;
        bad_q <= bad_now;
        if (pos_q == PosThird) begin
          third_pad_q <= is_pad;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/b64d_emit.sv =====
// Result register that serialises a decoded group into single-byte transfers.
`default_nettype none
module b64d_emit import b64d_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       grp_valid_i,
  input  wire group_res_t grp_i,
  output logic            grp_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_item_t       out_item_o
);

  logic [BytesPerGroup-1:0][7:0] bytes_q;
  logic [1:0]                    cnt_q;
  logic                          end_q;
  logic                          lerr_q;
  logic                          bad_q;
  logic                          out_xfer;
  logic                          load;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_xfer    = out_valid_o & ~out_stall_i;
  // A new group may enter once the last pending byte leaves.
  assign grp_ready_o = (cnt_q == 2'd0) | ((cnt_q == 2'd1) & out_xfer);
  assign load        = grp_valid_i & grp_ready_o;

  // Present the head byte with its flags.
  always_comb begin
    out_item_o.out_byte     = bytes_q[BytesPerGroup-1];
    out_item_o.run_last     = (cnt_q == 2'd1);
    out_item_o.stream_end   = (cnt_q == 2'd1) & end_q;
    out_item_o.length_error = lerr_q;
    out_item_o.bad_char     = bad_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load) begin
      cnt_q <= grp_i.count;
    end else if (out_xfer) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Bytes are kept most significant first, so the head sits at the top.
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (grp_i.length_error) begin
        bytes_q <= {grp_i.bytes[0], 16'h0000};
      end else begin
        bytes_q <= grp_i.bytes;
      end
      end_q  <= grp_i.stream_end;
      lerr_q <= grp_i.length_error;
      bad_q  <= grp_i.bad_char;
    end else if (out_xfer) begin
      bytes_q <= {bytes_q[1], bytes_q[0], 8'h00};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/base64_stream_decoder.sv =====
// Top level of the streaming base64 decoder.
// A character waits in the decoder's input register; its group's bytes go to the
// emitter's result register, which sets the output rate. One character per cycle
// unless stalled; a group's bytes, up to three, leave one per cycle unless the
// output stalls; the input stalls only if a group ends with bytes still pending.
// Reset clears the group state and all valid flags; no item is in flight after it.
`default_nettype none
module base64_stream_decoder import b64d_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  logic       grp_valid;
  logic       grp_ready;
  group_res_t grp;

  // Character decoding and group accumulation.
  b64d_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .grp_ready_i (grp_ready),
    .grp_valid_o (grp_valid),
    .grp_o       (grp)
  );

  // Byte serialisation onto the output channel.
  b64d_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (grp_valid),
    .grp_i       (grp),
    .grp_ready_o (grp_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the streaming base64 decoder.
module testbench;
  import b64d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One row of the directed stimulus; want is used only where typed is set.
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } row_t;

  localparam out_item_t NoWant = '0;

  // Directed stimulus: early ends, extreme values, padding in the third and fourth positions and stray bytes.
  localparam row_t DirectedRows [24] = '{
    // Early end straight after reset.
    '{'{"A", 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0}},
    // Early end on a byte above the alphabet.
    '{'{8'hFF, 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1}},
    // Highest sextets everywhere: three bytes of all ones.
    '{'{"/", 1'b0}, 1'b0, NoWant},
    '{'{"/", 1'b0}, 1'b0, NoWant},
    '{'{"/", 1'b0}, 1'b0, NoWant},
    '{'{"/", 1'b1}, 1'b0, NoWant},
    // Final group with double padding leaves one byte.
    '{'{"Q", 1'b0}, 1'b0, NoWant},
    '{'{"Q", 1'b0}, 1'b0, NoWant},
    '{'{"=", 1'b0}, 1'b0, NoWant},
    '{'{"=", 1'b1}, 1'b1, '{8'h41, 1'b1, 1'b1, 1'b0, 1'b0}},
    // Final group with single padding leaves two bytes.
    '{'{"Q", 1'b0}, 1'b0, NoWant},
    '{'{"U", 1'b0}, 1'b0, NoWant},
    '{'{"I", 1'b0}, 1'b0, NoWant},
    '{'{"=", 1'b1}, 1'b0, NoWant},
    // Padding in a group that is not final still gives three bytes.
    '{'{"+", 1'b0}, 1'b0, NoWant},
    '{'{"a", 1'b0}, 1'b0, NoWant},
    '{'{"9", 1'b0}, 1'b0, NoWant},
    '{'{"=", 1'b0}, 1'b0, NoWant},
    // Partial group holding a stray byte, then an early end.
    '{'{8'h80, 1'b0}, 1'b0, NoWant},
    '{'{8'h00, 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1}},
    // Padding only in the third position of a final group.
    '{'{"A", 1'b0}, 1'b0, NoWant},
    '{'{"B", 1'b0}, 1'b0, NoWant},
    '{'{"=", 1'b0}, 1'b0, NoWant},
    '{'{"C", 1'b1}, 1'b0, NoWant}
  };

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // Decoder state as predicted.
  logic [25:0] grp_sum       = '0;
  logic [1:0]  grp_pos       = PosFirst;
  logic        grp_third_pad = 1'b0;
  logic        grp_bad       = 1'b0;

  out_item_t expected_bytes [$];
  int        chars_sent    = 0;
  int        results_seen  = 0;
  int        mismatches    = 0;
  int        hold_left     = 0;
  bit        pressure_done = 1'b0;
  bit        quiet         = 1'b0;

  base64_stream_decoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Reset is held at the start of the run only.
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Alphabet position of a character; the pad gives 0 and anything else outside the alphabet 64.
  function automatic logic [6:0] char_sextet(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return 7'(ch - "A");
    if (ch >= "a" && ch <= "z") return 7'(ch - "a" + 26);
    if (ch >= "0" && ch <= "9") return 7'(ch - "0" + 52);
    if (ch == PlusChar) return PlusSextet;
    if (ch == SlashChar) return SlashSextet;
    if (ch == PadChar) return 7'd0;
    return UnknownSextet;
  endfunction

  // Character that stands for a given sextet.
  function automatic logic [7:0] alphabet_char(input int idx);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    return (idx == 62) ? PlusChar : SlashChar;
  endfunction

  task automatic clear_group();
    grp_sum       = '0;
    grp_pos       = PosFirst;
    grp_third_pad = 1'b0;
    grp_bad       = 1'b0;
  endtask

  // Appends one expected result to the back of the queue.
  task automatic queue_expected(input out_item_t res);
    expected_bytes.insert(expected_bytes.size(), res);
  endtask

  // Advances the predicted state by one character and, when record is set, queues the results it yields.
  task automatic decode_char(input in_item_t it, input bit record);
    logic [6:0]  sx;
    logic        bad;
    logic [25:0] sum;
    int          n;
    out_item_t   res;
    sx  = char_sextet(it.in_char);
    bad = grp_bad | (sx == UnknownSextet);
    sum = grp_sum + (26'(sx) << (6 * (PosFourth - grp_pos)));
    if (grp_pos != PosFourth) begin
      if (it.in_last) begin
        // The stream ended part-way through a group.
        res = '{8'h00, 1'b1, 1'b1, 1'b1, bad};
        if (record) queue_expected(res);
        clear_group();
      end else begin
        if (grp_pos == PosThird) grp_third_pad = (it.in_char == PadChar);
        grp_sum = sum;
        grp_pos = grp_pos + 2'd1;
        grp_bad = bad;
      end
    end else begin
      // Group complete: padding trims the byte count only in the final group.
      n = 3;
      if (it.in_last) n = n - int'(it.in_char == PadChar) - int'(grp_third_pad);
      for (int k = 0; k < n; k++) begin
        res.out_byte     = sum[23 - 8 * k -: 8];
        res.run_last     = (k == n - 1);
        res.stream_end   = (k == n - 1) && it.in_last;
        res.length_error = 1'b0;
        res.bad_char     = bad;
        if (record) queue_expected(res);
      end
      clear_group();
    end
  endtask

  // Offers one character, with random idle cycles first unless quiet, and waits for its transfer.
  task automatic send_char(input in_item_t it, input logic typed, input out_item_t want);
    while (!quiet && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    decode_char(it, !typed);
    if (typed) queue_expected(want);
    chars_sent++;
    quiet = (chars_sent >= 120 && chars_sent < 200);
  endtask

  // Well-formed stream of one to four groups, with the odd stray byte or early pad.
  task automatic send_stream();
    int       groups;
    int       pads;
    bit       final_grp;
    in_item_t it;
    groups = $urandom_range(1, 4);
    pads   = $urandom_range(0, 3);
    for (int g = 0; g < groups; g++) begin
      for (int p = 0; p < 4; p++) begin
        final_grp  = (g == groups - 1);
        it.in_char = alphabet_char($urandom_range(0, 63));
        if (final_grp && ((pads == 3) ? (p == 2) : (p >= 4 - pads))) begin
          it.in_char = PadChar;
        end else if ($urandom_range(0, 99) < 3) begin
          it.in_char = PadChar;
        end else if ($urandom_range(0, 99) < 3) begin
          it.in_char = 8'($urandom_range(0, 255));
        end
        it.in_last = final_grp && (p == 3);
        send_char(it, 1'b0, NoWant);
      end
    end
  endtask

  // Arbitrary bytes and end marks, mostly giving broken stream lengths.
  task automatic send_noise();
    int       n;
    in_item_t it;
    n = $urandom_range(1, 7);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0:       it.in_char = PadChar;
        1:       it.in_char = alphabet_char($urandom_range(0, 63));
        default: it.in_char = 8'($urandom_range(0, 255));
      endcase
      it.in_last = (k == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 9) == 0);
      send_char(it, 1'b0, NoWant);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Receiving side: checks each output transfer, then chooses the next stall value.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, out_item_o);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        check_field("out_byte", want.out_byte, out_item_o.out_byte);
        check_field("run_last", 8'(want.run_last), 8'(out_item_o.run_last));
        check_field("stream_end", 8'(want.stream_end), 8'(out_item_o.stream_end));
        check_field("length_error", 8'(want.length_error), 8'(out_item_o.length_error));
        check_field("bad_char", 8'(want.bad_char), 8'(out_item_o.bad_char));
      end
    end
    // One long hold-off so that the decoder backs up and stalls its input.
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!pressure_done && results_seen >= 30) begin
      pressure_done = 1'b1;
      hold_left     = 80;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 14);
    end
  end

  // Stimulus and end of run.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    foreach (DirectedRows[i]) begin
      send_char(DirectedRows[i].item, DirectedRows[i].typed, DirectedRows[i].want);
    end
    while (chars_sent < 350) begin
      if ($urandom_range(0, 99) < 80) send_stream();
      else send_noise();
    end
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #200000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/b64d_pkg.sv
rtl/b64d_decode.sv
rtl/b64d_emit.sv
rtl/base64_stream_decoder.sv
tb/sv/testbench.sv
